FILE: hw/rtl/sas_pkg.sv
package sas_pkg;

    localparam int OPCODE_W   = 2;
    localparam int FRAMES_W   = 8;
    localparam int TILE_W     = 12;
    localparam int OFF_W      = 10;
    localparam int GRID_W     = 7;
    localparam int POS_W      = 12;
    localparam int DRAW_W     = 13;
    localparam int STATUS_W   = 2;
    localparam int STEP_IDX_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = 4;

    localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PLAY    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_V = 2'd2;

    typedef struct packed {
        logic [FRAMES_W-1:0] frames;
        logic [TILE_W-1:0]   tile;
        logic [OFF_W-1:0]    off_x;
        logic [OFF_W-1:0]    off_y;
        logic [GRID_W-1:0]   cols;
        logic [GRID_W-1:0]   rows;
    } step_t;

    localparam int STEP_W = $bits(step_t);

    typedef struct packed {
        logic              start;
        logic [TILE_W-1:0] dividend;
        logic [GRID_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TILE_W-1:0] quotient;
        logic [GRID_W-1:0] remainder;
    } div_resp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_MUL,
        S_UPD,
        S_CHK,
        S_EMIT
    } state_t;

endpackage

FILE: hw/rtl/sas_ram.sv
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sas_div.sv
module sas_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sas_pkg::div_req_t    req,
    output sas_pkg::div_resp_t   resp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [sas_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [sas_pkg::TILE_W-1:0]          quo_reg, quo_next;
    logic [sas_pkg::GRID_W-1:0]          rem_reg, rem_next;
    logic [sas_pkg::GRID_W-1:0]          dvs_reg, dvs_next;
    logic [sas_pkg::GRID_W:0]            trial;
    logic [sas_pkg::GRID_W:0]            diff;
    logic                                fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[sas_pkg::TILE_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = sas_pkg::DIV_CNT_W'(sas_pkg::TILE_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[sas_pkg::TILE_W-2:0], fits};
            rem_next = fits ? diff[sas_pkg::GRID_W-1:0] : trial[sas_pkg::GRID_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg;

endmodule

FILE: hw/rtl/sprite_animation_sequencer_unit.sv
// Add, restart and unused items go from idle straight to the emit state, which registers the
// result to the outputs once the output is free; a new item is taken only back in idle.
// Play without mirroring: the read, update, check and emit states follow in turn.
// Play with mirroring: read, divide (until the serial divide is done), multiply, update, check, emit.
// Reset clears the step count, current step and frame counter; repeat mode resets to 1, mirrors to 0.
// The step memory is not cleared; only entries below the step count are ever read.
module sprite_animation_sequencer_unit #(
    parameter int MAX_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sas_pkg::OPCODE_W-1:0]        opcode,
    input  logic [sas_pkg::FRAMES_W-1:0]        step_frames,
    input  logic [sas_pkg::TILE_W-1:0]          step_tile,
    input  logic signed [sas_pkg::OFF_W-1:0]    step_off_x,
    input  logic signed [sas_pkg::OFF_W-1:0]    step_off_y,
    input  logic [sas_pkg::GRID_W-1:0]          grid_cols,
    input  logic [sas_pkg::GRID_W-1:0]          grid_rows,
    input  logic signed [sas_pkg::POS_W-1:0]    pos_x,
    input  logic signed [sas_pkg::POS_W-1:0]    pos_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sas_pkg::STATUS_W-1:0]        status,
    output logic [sas_pkg::TILE_W-1:0]          tile_index,
    output logic signed [sas_pkg::DRAW_W-1:0]   draw_x,
    output logic signed [sas_pkg::DRAW_W-1:0]   draw_y,
    output logic                                draw_flip_h,
    output logic                                draw_flip_v,
    output logic [sas_pkg::STEP_IDX_W-1:0]      step_index,
    output logic                                sequence_done,
    input  logic                                cfg_we,
    input  logic [sas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic                                cfg_data
);

    localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    sas_pkg::state_t                   state_reg, state_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [IDX_W-1:0]                  cur_reg, cur_next;
    logic [sas_pkg::FRAMES_W-1:0]      frame_reg, frame_next;
    logic                              repeat_reg, repeat_next;
    logic                              mirror_h_reg, mirror_h_next;
    logic                              mirror_v_reg, mirror_v_next;
    logic                              out_valid_reg, out_valid_next;

    sas_pkg::step_t                    ent_reg, ent_next;
    logic [sas_pkg::POS_W-1:0]         pos_x_reg, pos_x_next;
    logic [sas_pkg::POS_W-1:0]         pos_y_reg, pos_y_next;
    logic [sas_pkg::GRID_W-1:0]        ix_reg, ix_next;
    logic [sas_pkg::TILE_W-1:0]        iy_reg, iy_next;
    logic [sas_pkg::TILE_W-1:0]        tile_reg, tile_next;
    logic [sas_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic                              res_play_reg, res_play_next;
    logic [sas_pkg::DRAW_W-1:0]        res_dx_reg, res_dx_next;
    logic [sas_pkg::DRAW_W-1:0]        res_dy_reg, res_dy_next;
    logic                              res_done_reg, res_done_next;

    logic [sas_pkg::STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [sas_pkg::TILE_W-1:0]        out_tile_reg, out_tile_next;
    logic [sas_pkg::DRAW_W-1:0]        out_dx_reg, out_dx_next;
    logic [sas_pkg::DRAW_W-1:0]        out_dy_reg, out_dy_next;
    logic                              out_fh_reg, out_fh_next;
    logic                              out_fv_reg, out_fv_next;
    logic [sas_pkg::STEP_IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic                              out_done_reg, out_done_next;

    logic                              in_xfer;
    logic                              out_free;
    logic                              table_full;
    logic                              mirror_any;

    logic                              ram_we;
    logic [IDX_W-1:0]                  ram_waddr;
    sas_pkg::step_t                    ram_wstep;
    logic                              ram_re;
    logic [IDX_W-1:0]                  ram_raddr;
    logic [sas_pkg::STEP_W-1:0]        ram_rdata;
    sas_pkg::step_t                    rd_step;

    sas_pkg::div_req_t                 div_req;
    sas_pkg::div_resp_t                div_resp;

    logic [sas_pkg::GRID_W-1:0]        cx;
    logic [sas_pkg::GRID_W-1:0]        rd_cx;
    logic [sas_pkg::TILE_W-1:0]        mul_lo;
    logic [sas_pkg::DRAW_W-1:0]        offx_ext;
    logic [sas_pkg::DRAW_W-1:0]        offy_ext;

    logic [CNT_W-1:0]                  step_inc;
    logic                              last_step;
    logic [sas_pkg::FRAMES_W:0]        frame_inc;
    logic [sas_pkg::FRAMES_W-1:0]      len_cur;
    logic [sas_pkg::FRAMES_W-1:0]      len_new;
    logic                              end_now;
    logic                              advance;
    logic                              frame_wrap;
    logic [IDX_W-1:0]                  upd_step;
    logic [sas_pkg::FRAMES_W-1:0]      upd_frame;

    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign table_full = (count_reg >= CNT_W'(MAX_STEPS));
    assign mirror_any = mirror_h_reg || mirror_v_reg;
    assign rd_step    = sas_pkg::step_t'(ram_rdata);

    assign ram_we          = in_xfer && (opcode == sas_pkg::OP_ADD) && !table_full;
    assign ram_waddr       = count_reg[IDX_W-1:0];
    assign ram_wstep.frames = step_frames;
    assign ram_wstep.tile   = step_tile;
    assign ram_wstep.off_x  = step_off_x;
    assign ram_wstep.off_y  = step_off_y;
    assign ram_wstep.cols   = grid_cols;
    assign ram_wstep.rows   = grid_rows;

    sas_ram #(
        .WIDTH (sas_pkg::STEP_W),
        .DEPTH (MAX_STEPS)
    ) u_step_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wstep),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // A grid with zero columns mirrors as a single column.
    assign cx    = (ent_reg.cols == '0) ? sas_pkg::GRID_W'(1) : ent_reg.cols;
    assign rd_cx = (rd_step.cols == '0) ? sas_pkg::GRID_W'(1) : rd_step.cols;
    assign mul_lo = iy_reg * sas_pkg::TILE_W'(cx);

    assign offx_ext = {{(sas_pkg::DRAW_W - sas_pkg::OFF_W){ent_reg.off_x[sas_pkg::OFF_W-1]}},
                       ent_reg.off_x};
    assign offy_ext = {{(sas_pkg::DRAW_W - sas_pkg::OFF_W){ent_reg.off_y[sas_pkg::OFF_W-1]}},
                       ent_reg.off_y};

    // A step of zero frames lasts one frame for the end test.
    assign len_cur   = (ent_reg.frames == '0) ? sas_pkg::FRAMES_W'(1) : ent_reg.frames;
    assign len_new   = (rd_step.frames == '0) ? sas_pkg::FRAMES_W'(1) : rd_step.frames;
    assign step_inc  = CNT_W'(cur_reg) + CNT_W'(1);
    assign last_step = (step_inc >= count_reg);
    assign frame_inc = {1'b0, frame_reg} + (sas_pkg::FRAMES_W + 1)'(1);
    assign end_now   = last_step && (frame_inc >= {1'b0, len_cur});
    assign advance   = repeat_reg || !end_now;
    assign frame_wrap = (frame_inc >= {1'b0, ent_reg.frames});

    always_comb
    begin
        upd_step  = cur_reg;
        upd_frame = frame_reg;
        if (advance)
        begin
            if (frame_wrap)
            begin
                upd_frame = '0;
                upd_step  = last_step ? '0 : step_inc[IDX_W-1:0];
            end
            else
            begin
                upd_frame = frame_inc[sas_pkg::FRAMES_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sas_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((opcode == sas_pkg::OP_PLAY) && (count_reg != '0))
                    begin
                        state_next = sas_pkg::S_READ;
                    end
                    else
                    begin
                        state_next = sas_pkg::S_EMIT;
                    end
                end
            end
            sas_pkg::S_READ:
            begin
                state_next = mirror_any ? sas_pkg::S_DIV : sas_pkg::S_UPD;
            end
            sas_pkg::S_DIV:
            begin
                if (div_resp.done)
                begin
                    state_next = sas_pkg::S_MUL;
                end
            end
            sas_pkg::S_MUL:
            begin
                state_next = sas_pkg::S_UPD;
            end
            sas_pkg::S_UPD:
            begin
                state_next = sas_pkg::S_CHK;
            end
            sas_pkg::S_CHK:
            begin
                state_next = sas_pkg::S_EMIT;
            end
            sas_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = sas_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sas_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall         = 1'b1;
        ram_re           = 1'b0;
        ram_raddr        = cur_reg;
        div_req.start    = 1'b0;
        div_req.dividend = rd_step.tile;
        div_req.divisor  = rd_cx;
        case (state_reg)
            sas_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                ram_re   = in_valid && (opcode == sas_pkg::OP_PLAY) && (count_reg != '0);
            end
            sas_pkg::S_READ:
            begin
                div_req.start = mirror_any;
            end
            sas_pkg::S_UPD:
            begin
                ram_re    = 1'b1;
                ram_raddr = upd_step;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        cur_next        = cur_reg;
        frame_next      = frame_reg;
        repeat_next     = repeat_reg;
        mirror_h_next   = mirror_h_reg;
        mirror_v_next   = mirror_v_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ent_next        = ent_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        ix_next         = ix_reg;
        iy_next         = iy_reg;
        tile_next       = tile_reg;
        res_status_next = res_status_reg;
        res_play_next   = res_play_reg;
        res_dx_next     = res_dx_reg;
        res_dy_next     = res_dy_reg;
        res_done_next   = res_done_reg;
        out_status_next = out_status_reg;
        out_tile_next   = out_tile_reg;
        out_dx_next     = out_dx_reg;
        out_dy_next     = out_dy_reg;
        out_fh_next     = out_fh_reg;
        out_fv_next     = out_fv_reg;
        out_idx_next    = out_idx_reg;
        out_done_next   = out_done_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                sas_pkg::CFG_REPEAT:   repeat_next   = cfg_data;
                sas_pkg::CFG_MIRROR_H: mirror_h_next = cfg_data;
                sas_pkg::CFG_MIRROR_V: mirror_v_next = cfg_data;
                default:               repeat_next   = repeat_reg;
            endcase
        end

        case (state_reg)
            sas_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    res_status_next = sas_pkg::ST_OK;
                    res_play_next   = 1'b0;
                    res_dx_next     = '0;
                    res_dy_next     = '0;
                    res_done_next   = 1'b0;
                    pos_x_next      = pos_x;
                    pos_y_next      = pos_y;
                    case (opcode)
                        sas_pkg::OP_ADD:
                        begin
                            if (table_full)
                            begin
                                res_status_next = sas_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        sas_pkg::OP_PLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = sas_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                res_play_next = 1'b1;
                            end
                        end
                        sas_pkg::OP_RESTART:
                        begin
                            cur_next   = '0;
                            frame_next = '0;
                        end
                        default:
                        begin
                            res_status_next = sas_pkg::ST_OK;
                        end
                    endcase
                end
            end
            sas_pkg::S_READ:
            begin
                ent_next  = rd_step;
                tile_next = rd_step.tile;
            end
            sas_pkg::S_DIV:
            begin
                if (div_resp.done)
                begin
                    ix_next = mirror_h_reg ? (cx - div_resp.remainder - sas_pkg::GRID_W'(1))
                                           : div_resp.remainder;
                    iy_next = mirror_v_reg ? (sas_pkg::TILE_W'(ent_reg.rows) - div_resp.quotient
                                              - sas_pkg::TILE_W'(1))
                                           : div_resp.quotient;
                end
            end
            sas_pkg::S_MUL:
            begin
                tile_next = mul_lo + sas_pkg::TILE_W'(ix_reg);
            end
            sas_pkg::S_UPD:
            begin
                res_dx_next = {pos_x_reg[sas_pkg::POS_W-1], pos_x_reg}
                              + (mirror_h_reg ? (-offx_ext) : offx_ext);
                res_dy_next = {pos_y_reg[sas_pkg::POS_W-1], pos_y_reg}
                              + (mirror_v_reg ? (-offy_ext) : offy_ext);
                cur_next    = upd_step;
                frame_next  = upd_frame;
            end
            sas_pkg::S_CHK:
            begin
                res_done_next = last_step && (frame_inc >= {1'b0, len_new});
            end
            sas_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_tile_next   = res_play_reg ? tile_reg : '0;
                    out_dx_next     = res_dx_reg;
                    out_dy_next     = res_dy_reg;
                    out_fh_next     = res_play_reg && mirror_h_reg;
                    out_fv_next     = res_play_reg && mirror_v_reg;
                    out_idx_next    = sas_pkg::STEP_IDX_W'(cur_reg);
                    out_done_next   = res_done_reg;
                end
            end
            default:
            begin
                out_done_next = out_done_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sas_pkg::S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            frame_reg     <= '0;
            repeat_reg    <= 1'b1;
            mirror_h_reg  <= 1'b0;
            mirror_v_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            frame_reg     <= frame_next;
            repeat_reg    <= repeat_next;
            mirror_h_reg  <= mirror_h_next;
            mirror_v_reg  <= mirror_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg        <= ent_next;
        pos_x_reg      <= pos_x_next;
        pos_y_reg      <= pos_y_next;
        ix_reg         <= ix_next;
        iy_reg         <= iy_next;
        tile_reg       <= tile_next;
        res_status_reg <= res_status_next;
        res_play_reg   <= res_play_next;
        res_dx_reg     <= res_dx_next;
        res_dy_reg     <= res_dy_next;
        res_done_reg   <= res_done_next;
        out_status_reg <= out_status_next;
        out_tile_reg   <= out_tile_next;
        out_dx_reg     <= out_dx_next;
        out_dy_reg     <= out_dy_next;
        out_fh_reg     <= out_fh_next;
        out_fv_reg     <= out_fv_next;
        out_idx_reg    <= out_idx_next;
        out_done_reg   <= out_done_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign tile_index    = out_tile_reg;
    assign draw_x        = out_dx_reg;
    assign draw_y        = out_dy_reg;
    assign draw_flip_h   = out_fh_reg;
    assign draw_flip_v   = out_fv_reg;
    assign step_index    = out_idx_reg;
    assign sequence_done = out_done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_STEPS))
        else $error("step count exceeds table depth");

    a_step_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || (CNT_W'(cur_reg) < count_reg))
        else $error("current step lies outside the filled table");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_resp.done |-> (state_reg == sas_pkg::S_DIV))
        else $error("divider finished outside its wait state");

    a_emit_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sas_pkg::S_EMIT) && out_free |=> out_valid_reg)
        else $error("result lost at emit");

endmodule
